// ----- hw/rtl/tmwf_pkg.sv -----
// ----------------------------------------------------------------------------
// tmwf_pkg
// shared widths, constants, types and state codes of the trimmed mean filter
// ----------------------------------------------------------------------------
package tmwf_pkg;

  localparam int WINDOW_SIZE = 12;
  localparam int AXES        = 3;
  localparam int AXIS_W      = 2;
  localparam int SAMPLE_W    = 16;
  localparam int MEAN_W      = 24;
  localparam int FRAC_BITS   = 8;

  localparam int SLOT_W   = $clog2(WINDOW_SIZE);
  localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW_SIZE);
  // |sum - min - max| <= (WINDOW_SIZE - 2) * 2^15
  localparam int MAG_W    = SUM_W - 1;
  localparam int TRIM_W   = SUM_W;
  localparam int ENTRY_W  = AXES * SAMPLE_W;

  // divide by a constant through reciprocal multiplies
  localparam int DIV_D    = WINDOW_SIZE - 2;
  localparam int DIV_L    = $clog2(DIV_D);
  localparam int REM_W    = (DIV_L > 0) ? DIV_L : 1;
  localparam int SHIFT_A  = MAG_W + DIV_L;
  localparam int REM_K    = FRAC_BITS + DIV_L;
  localparam int SHIFT_B  = REM_K + DIV_L;
  localparam int MUL_W    = MAG_W + 1;
  localparam int PROD_W   = MAG_W + MUL_W;

  localparam logic [MUL_W-1:0] RECIP_A =
    MUL_W'(((64'd1 << SHIFT_A) + 64'(DIV_D) - 64'd1) / 64'(DIV_D));
  localparam logic [MUL_W-1:0] RECIP_B =
    MUL_W'(((64'd1 << SHIFT_B) + 64'(DIV_D) - 64'd1) / 64'(DIV_D));

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [TRIM_W-1:0]   trim_t;
  typedef logic signed [MEAN_W-1:0]   mean_t;

  typedef struct packed {
    logic vld;
    logic first;
  } scan_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } top_state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_QUO,
    DV_REM,
    DV_FRAC
  } div_state_t;

endpackage

// ----- hw/rtl/tmwf_win_mem.sv -----
// ----------------------------------------------------------------------------
// tmwf_win_mem
// sample window store, one write and one registered read port
// ----------------------------------------------------------------------------
module tmwf_win_mem (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [tmwf_pkg::SLOT_W-1:0]   wr_addr,
  input  logic [tmwf_pkg::ENTRY_W-1:0]  wr_data,
  input  logic                          rd_en,
  input  logic [tmwf_pkg::SLOT_W-1:0]   rd_addr,
  output logic [tmwf_pkg::ENTRY_W-1:0]  rd_data
);
  import tmwf_pkg::*;

  logic [ENTRY_W-1:0] mem [WINDOW_SIZE];
  logic [ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/tmwf_stats.sv -----
// ----------------------------------------------------------------------------
// tmwf_stats
// running sum, minimum and maximum over the scanned window, one entry a cycle
// ----------------------------------------------------------------------------
module tmwf_stats (
  input  logic                  clk,
  input  tmwf_pkg::scan_ctl_t   ctl,
  input  tmwf_pkg::sample_t     sample [tmwf_pkg::AXES],
  output tmwf_pkg::trim_t       trim   [tmwf_pkg::AXES]
);
  import tmwf_pkg::*;

  logic signed [SUM_W-1:0]   sum_r [AXES];
  sample_t                   lo_r  [AXES];
  sample_t                   hi_r  [AXES];
  logic signed [SUM_W+1:0]   wide  [AXES];

  always_ff @(posedge clk) begin
    if (ctl.vld) begin
      for (int a = 0; a < AXES; a++) begin
        if (ctl.first) begin
          sum_r[a] <= SUM_W'(sample[a]);
          lo_r[a]  <= sample[a];
          hi_r[a]  <= sample[a];
        end else begin
          sum_r[a] <= sum_r[a] + SUM_W'(sample[a]);
          if (sample[a] < lo_r[a]) begin
            lo_r[a] <= sample[a];
          end
          if (sample[a] > hi_r[a]) begin
            hi_r[a] <= sample[a];
          end
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      wide[a] = (SUM_W+2)'(sum_r[a]) - (SUM_W+2)'(lo_r[a]) - (SUM_W+2)'(hi_r[a]);
      trim[a] = TRIM_W'(wide[a]);
    end
  end

endmodule

// ----- hw/rtl/tmwf_div.sv -----
// ----------------------------------------------------------------------------
// tmwf_div
// scaled division by the trimmed count, one shared multiplier stepped by a
// small sequencer: quotient, remainder and fraction products for each axis
// ----------------------------------------------------------------------------
module tmwf_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  tmwf_pkg::trim_t    trim [tmwf_pkg::AXES],
  output logic               done,
  output tmwf_pkg::mean_t    mean [tmwf_pkg::AXES]
);
  import tmwf_pkg::*;

  div_state_t               state_r, state_nxt;
  logic [AXIS_W-1:0]        axis_r, axis_nxt;
  logic                     done_r, done_nxt;
  trim_t                    t_r [AXES];
  logic [MAG_W-1:0]         a_r;
  logic [REM_W-1:0]         r_r;
  mean_t                    q_r [AXES];

  trim_t                    cur_t;
  logic                     neg;
  logic [MAG_W-1:0]         mag;
  logic [MAG_W-1:0]         mul_a;
  logic [MUL_W-1:0]         mul_b;
  logic [PROD_W-1:0]        prod;
  logic [FRAC_BITS-1:0]     frac;
  logic [MEAN_W-1:0]        qmag;
  mean_t                    qres;

  assign cur_t = t_r[axis_r];
  assign neg   = cur_t[TRIM_W-1];
  assign mag   = neg ? MAG_W'(-cur_t) : MAG_W'(cur_t);

  // the shared multiplier
  assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign frac  = FRAC_BITS'(prod >> SHIFT_B);
  assign qmag  = (MEAN_W'(a_r) << FRAC_BITS) + MEAN_W'(frac);
  assign qres  = neg ? mean_t'(-qmag) : mean_t'(qmag);

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    done_nxt  = 1'b0;
    mul_a     = mag;
    mul_b     = RECIP_A;
    case (state_r)
      DV_IDLE: begin
        if (start) begin
          state_nxt = DV_QUO;
          axis_nxt  = '0;
        end
      end
      DV_QUO: begin
        state_nxt = DV_REM;
      end
      DV_REM: begin
        mul_a     = a_r;
        mul_b     = MUL_W'(DIV_D);
        state_nxt = DV_FRAC;
      end
      DV_FRAC: begin
        mul_a = MAG_W'(r_r) << FRAC_BITS;
        mul_b = RECIP_B;
        if (axis_r == AXIS_W'(AXES - 1)) begin
          state_nxt = DV_IDLE;
          done_nxt  = 1'b1;
        end else begin
          state_nxt = DV_QUO;
          axis_nxt  = axis_r + AXIS_W'(1);
        end
      end
      default: begin
        state_nxt = DV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
      axis_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == DV_IDLE && start) begin
      for (int a = 0; a < AXES; a++) begin
        t_r[a] <= trim[a];
      end
    end
    if (state_r == DV_QUO) begin
      a_r <= MAG_W'(prod >> SHIFT_A);
    end
    // remainder is below the divisor
    if (state_r == DV_REM) begin
      r_r <= REM_W'(mag - MAG_W'(prod));
    end
    if (state_r == DV_FRAC) begin
      q_r[axis_r] <= qres;
    end
  end

  assign done = done_r;
  assign mean = q_r;

endmodule

// ----- hw/rtl/trimmed_mean_window_filter.sv -----
// ----------------------------------------------------------------------------
// trimmed_mean_window_filter
// sliding window trimmed mean over three sensor axes, 8 fraction bits out
// ----------------------------------------------------------------------------
// usage
//   in_*  : one three-axis sample per item, valid/ready
//   out_* : one trimmed mean per axis per item, valid/ready
//   the last WINDOW_SIZE samples are kept in arrival order; each item drops
//   one minimum and one maximum and returns (sum - min - max) * 256 / (N - 2)
//   per axis, truncated toward zero
//   while the window is still filling, an item gives no result and in_ready
//   stays high
//   once filled, an item passes the window scan over the single read port,
//   a drain state, a load state, the divider and the output state, and
//   in_ready stays low until it is through; the divider's shared multiplier
//   runs three products per axis
//   a finished result waits in the output register while the next item is
//   taken; if out_ready stays low the next result holds back until it drains
//   reset empties the window and clears out_valid; no clearing pass
// ----------------------------------------------------------------------------
module trimmed_mean_window_filter (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  tmwf_pkg::sample_t         in_sample_x,
  input  tmwf_pkg::sample_t         in_sample_y,
  input  tmwf_pkg::sample_t         in_sample_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output tmwf_pkg::mean_t           out_mean_x,
  output tmwf_pkg::mean_t           out_mean_y,
  output tmwf_pkg::mean_t           out_mean_z
);
  import tmwf_pkg::*;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_SIZE - 1);

  top_state_t          state_r, state_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic                full_r, full_nxt;
  logic [SLOT_W-1:0]   cnt_r, cnt_nxt;
  scan_ctl_t           scan_ctl_r, scan_ctl_nxt;
  logic                out_valid_r, out_valid_nxt;
  mean_t               mean_x_r, mean_y_r, mean_z_r;

  logic                accept;
  logic                slot_last;
  logic                rd_en;
  logic                div_start;
  logic                div_done;
  logic                load;
  logic [ENTRY_W-1:0]  rd_data;
  sample_t             rd_sample [AXES];
  trim_t               trim      [AXES];
  mean_t               div_mean  [AXES];

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_last = (slot_r == SLOT_LAST);

  tmwf_win_mem u_mem (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (slot_r),
    .wr_data ({in_sample_z, in_sample_y, in_sample_x}),
    .rd_en   (rd_en),
    .rd_addr (cnt_r),
    .rd_data (rd_data)
  );

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      rd_sample[a] = sample_t'(rd_data[a*SAMPLE_W +: SAMPLE_W]);
    end
  end

  tmwf_stats u_stats (
    .clk    (clk),
    .ctl    (scan_ctl_r),
    .sample (rd_sample),
    .trim   (trim)
  );

  tmwf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .trim  (trim),
    .done  (div_done),
    .mean  (div_mean)
  );

  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    full_nxt  = full_r;
    cnt_nxt   = cnt_r;
    rd_en     = 1'b0;
    div_start = 1'b0;
    load      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          slot_nxt = slot_last ? '0 : slot_r + SLOT_W'(1);
          if (slot_last) begin
            full_nxt = 1'b1;
          end
          if (full_r || slot_last) begin
            state_nxt = ST_SCAN;
            cnt_nxt   = '0;
          end
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (cnt_r == SLOT_LAST) begin
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + SLOT_W'(1);
        end
      end
      // last read lands in the stats registers
      ST_DRAIN: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    scan_ctl_nxt.vld   = (state_r == ST_SCAN);
    scan_ctl_nxt.first = (state_r == ST_SCAN) && (cnt_r == '0);
    out_valid_nxt      = load || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= '0;
      full_r      <= 1'b0;
      cnt_r       <= '0;
      scan_ctl_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      full_r      <= full_nxt;
      cnt_r       <= cnt_nxt;
      scan_ctl_r  <= scan_ctl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mean_x_r <= div_mean[0];
      mean_y_r <= div_mean[1];
      mean_z_r <= div_mean[2];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_mean_x = mean_x_r;
  assign out_mean_y = mean_y_r;
  assign out_mean_z = mean_z_r;

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= SLOT_LAST)
    else $error("write slot out of range");

  a_no_result_before_full: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> full_r)
    else $error("result before window filled");

  a_fill_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !full_r && !slot_last) |=> (state_r == ST_IDLE))
    else $error("filling item started a scan");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider done outside wait state");

endmodule
